/* design/nbgs_pkg.sv */
package nbgs_pkg;

  // Default number of body slots.
  localparam int MaxBodiesDef = 16;

  // Field widths.
  localparam int POS_W      = 48;
  localparam int MU_W       = 32;
  localparam int DT_W       = 32;
  localparam int SOFT_W     = 32;
  localparam int CNT_W      = 5;
  localparam int IDX_PORT_W = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Internal arithmetic widths.
  localparam int ACC_W  = 64;   // acceleration sum, Q.32
  localparam int MAG_W  = 49;   // magnitude of a position difference
  localparam int SQ_W   = 50;   // truncated square, Q.16
  localparam int R2_W   = 52;   // softened squared distance, Q.16
  localparam int RT_W   = 26;   // square root, Q.8
  localparam int DEN_W  = 78;   // r2 * r, Q.24
  localparam int NUMB_W = 81;   // mu * |d| before the shift by 8
  localparam int NUM_W  = 89;   // dividend
  localparam int QUO_W  = 56;   // quotient bits below the cap
  localparam int TERM_W = 58;   // signed force term
  localparam int DTT_W  = 50;   // signed value times dt

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BODY_COUNT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTENING_SQ = 1'b1;

  // Reset values of the registers.
  localparam logic [CNT_W-1:0]  BODY_COUNT_RST = 5'd2;
  localparam logic [SOFT_W-1:0] SOFT_RST       = 32'd1;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic        [MU_W-1:0]  mu;
    logic signed [ACC_W-1:0] acc_x;
    logic signed [ACC_W-1:0] acc_y;
  } body_t;

endpackage

/* design/nbgs_if.sv */
interface nbgs_in_if import nbgs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [IDX_PORT_W-1:0]   body_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] vel_x;
  logic signed [POS_W-1:0] vel_y;
  logic [MU_W-1:0]         grav_param;
  logic [DT_W-1:0]         step_time;

  modport source (output valid, req_type, body_index, pos_x, pos_y, vel_x, vel_y,
                  grav_param, step_time, input ready);
  modport sink (input valid, req_type, body_index, pos_x, pos_y, vel_x, vel_y,
                grav_param, step_time, output ready);
endinterface

interface nbgs_out_if import nbgs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_PORT_W-1:0]   out_index;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_vel_x;
  logic signed [POS_W-1:0] out_vel_y;
  logic                    last_body;

  modport source (output valid, out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                  last_body, input ready);
  modport sink (input valid, out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y,
                last_body, output ready);
endinterface

/* design/nbgs_cell.sv */
module nbgs_cell import nbgs_pkg::*; (
  input  logic  clk_i,
  input  logic  ld_i,
  input  body_t ld_data_i,
  input  logic  sh_i,
  input  body_t nxt_i,
  output body_t body_o
);

  body_t body_q, body_d;

  // A load writes the slot; a shift takes the neighbor's body.
  always_comb begin
    body_d = body_q;
    if (ld_i) begin
      body_d = ld_data_i;
    end else if (sh_i) begin
      body_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    body_q <= body_d;
  end

  assign body_o = body_q;

endmodule

/* design/nbgs_div.sv */
module nbgs_div import nbgs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quot_o
);

  localparam int CW = $clog2(QUO_W);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [QUO_W-1:0] nsh_q, nsh_d, quo_q, quo_d;
  logic [DEN_W:0]   trial, diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle. The caller checks whether
  // the quotient fits and takes the cap instead when it does not; the quotient
  // is valid only when the top part of the dividend is below the divisor.
  always_comb begin
    trial  = {rem_q, nsh_q[QUO_W-1]};
    diff   = trial - {1'b0, den_q};
    ge     = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    nsh_d  = nsh_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QUO_W - 1);
      rem_d  = DEN_W'(num_i[NUM_W-1:QUO_W]);
      nsh_d  = num_i[QUO_W-1:0];
      den_d  = den_i;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      nsh_d = {nsh_q[QUO_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nsh_q <= nsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* design/nbgs_pair.sv */
module nbgs_pair import nbgs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [POS_W-1:0]  pi_x_i,
  input  logic signed [POS_W-1:0]  pi_y_i,
  input  logic signed [POS_W-1:0]  pj_x_i,
  input  logic signed [POS_W-1:0]  pj_y_i,
  input  logic        [MU_W-1:0]   mu_i,
  input  logic        [SOFT_W-1:0] soft_i,
  output logic                     done_o,
  output logic signed [TERM_W-1:0] term_x_o,
  output logic signed [TERM_W-1:0] term_y_o
);

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_SQ   = 4'd1;
  localparam logic [3:0] P_SUM  = 4'd2;
  localparam logic [3:0] P_SQRT = 4'd3;
  localparam logic [3:0] P_DEN0 = 4'd4;
  localparam logic [3:0] P_DEN1 = 4'd5;
  localparam logic [3:0] P_DEN2 = 4'd6;
  localparam logic [3:0] P_NUM0 = 4'd7;
  localparam logic [3:0] P_NUM1 = 4'd8;
  localparam logic [3:0] P_NUM2 = 4'd9;
  localparam logic [3:0] P_CMP  = 4'd10;
  localparam logic [3:0] P_DIV  = 4'd11;
  localparam logic [3:0] P_DONE = 4'd12;

  localparam int TX_W   = MAG_W - 16;
  localparam int MLO_W  = 25;
  localparam int MHI_W  = MAG_W - MLO_W;
  localparam int RLO_W  = R2_W / 2;
  localparam int RHI_W  = R2_W - RLO_W;
  localparam int CAP_SH = QUO_W - (NUM_W - NUMB_W);
  localparam int DLOW_W = NUMB_W - CAP_SH;

  logic [3:0] state_q, state_d;

  logic [MAG_W-1:0]          mx_q, mx_d, my_q, my_d;
  logic                      nx_q, nx_d, ny_q, ny_d;
  logic [MU_W-1:0]           mu_q, mu_d;
  logic [SOFT_W-1:0]         soft_q, soft_d;
  logic [SQ_W-1:0]           sqx_q, sqx_d, sqy_q, sqy_d;
  logic [R2_W-1:0]           r2_q, r2_d, srem_q, srem_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [RLO_W+RT_W-1:0]     plo_q, plo_d;
  logic [RHI_W+RT_W-1:0]     phi_q, phi_d;
  logic [DEN_W-1:0]          den_q, den_d;
  logic [MU_W+MLO_W-1:0]     nxl_q, nxl_d, nyl_q, nyl_d;
  logic [MU_W+MHI_W-1:0]     nxh_q, nxh_d, nyh_q, nyh_d;
  logic [NUMB_W-1:0]         numx_q, numx_d, numy_q, numy_d;
  logic                      capx_q, capx_d, capy_q, capy_d;
  logic signed [TERM_W-1:0]  tx_q, tx_d, ty_q, ty_d;

  logic signed [MAG_W-1:0]   dx, dy;
  logic [TX_W-1:0]           tqx, tqy;
  logic [2*TX_W-1:0]         psx, psy;
  logic [R2_W-1:0]           r2_sum, strial;
  logic [NUMB_W-1:0]         cap_lim;
  logic                      div_start;
  logic                      divx_done, divy_done;
  logic [QUO_W-1:0]          quox, quoy;
  logic [TERM_W-1:0]         magx, magy;

  always_comb begin
    dx      = {pj_x_i[POS_W-1], pj_x_i} - {pi_x_i[POS_W-1], pi_x_i};
    dy      = {pj_y_i[POS_W-1], pj_y_i} - {pi_y_i[POS_W-1], pi_y_i};
    tqx     = mx_q[MAG_W-1:16];
    tqy     = my_q[MAG_W-1:16];
    psx     = tqx * tqx;
    psy     = tqy * tqy;
    r2_sum  = R2_W'(sqx_q) + R2_W'(sqy_q) + R2_W'(soft_q);
    strial  = sres_q + sbit_q;
    cap_lim = {den_q[DLOW_W-1:0], {CAP_SH{1'b0}}};
    magx    = capx_q ? (TERM_W'(1) << QUO_W) : TERM_W'(quox);
    magy    = capy_q ? (TERM_W'(1) << QUO_W) : TERM_W'(quoy);

    state_d   = state_q;
    div_start = 1'b0;
    mx_d = mx_q;   my_d = my_q;   nx_d = nx_q;   ny_d = ny_q;
    mu_d = mu_q;   soft_d = soft_q;
    sqx_d = sqx_q; sqy_d = sqy_q;
    r2_d = r2_q;   srem_d = srem_q; sres_d = sres_q; sbit_d = sbit_q;
    plo_d = plo_q; phi_d = phi_q; den_d = den_q;
    nxl_d = nxl_q; nyl_d = nyl_q; nxh_d = nxh_q; nyh_d = nyh_q;
    numx_d = numx_q; numy_d = numy_q;
    capx_d = capx_q; capy_d = capy_q;
    tx_d = tx_q;   ty_d = ty_q;

    case (state_q)
      P_IDLE: begin
        if (start_i) begin
          nx_d    = dx[MAG_W-1];
          ny_d    = dy[MAG_W-1];
          mx_d    = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
          my_d    = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
          mu_d    = mu_i;
          soft_d  = soft_i;
          state_d = P_SQ;
        end
      end
      P_SQ: begin
        sqx_d   = psx[2*TX_W-1:16];
        sqy_d   = psy[2*TX_W-1:16];
        state_d = P_SUM;
      end
      P_SUM: begin
        r2_d = r2_sum;
        if (r2_sum == '0) begin
          // A zero denominator drops the pair.
          tx_d    = '0;
          ty_d    = '0;
          state_d = P_DONE;
        end else begin
          srem_d  = r2_sum;
          sres_d  = '0;
          sbit_d  = R2_W'(1) << (R2_W - 2);
          state_d = P_SQRT;
        end
      end
      P_SQRT: begin
        if (srem_q >= strial) begin
          srem_d = srem_q - strial;
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) begin
          state_d = P_DEN0;
        end
      end
      P_DEN0: begin
        plo_d   = r2_q[RLO_W-1:0] * sres_q[RT_W-1:0];
        state_d = P_DEN1;
      end
      P_DEN1: begin
        phi_d   = r2_q[R2_W-1:RLO_W] * sres_q[RT_W-1:0];
        state_d = P_DEN2;
      end
      P_DEN2: begin
        den_d   = {phi_q, {RLO_W{1'b0}}} + DEN_W'(plo_q);
        state_d = P_NUM0;
      end
      P_NUM0: begin
        nxl_d   = mu_q * mx_q[MLO_W-1:0];
        nyl_d   = mu_q * my_q[MLO_W-1:0];
        state_d = P_NUM1;
      end
      P_NUM1: begin
        nxh_d   = mu_q * mx_q[MAG_W-1:MLO_W];
        nyh_d   = mu_q * my_q[MAG_W-1:MLO_W];
        state_d = P_NUM2;
      end
      P_NUM2: begin
        numx_d  = {nxh_q, {MLO_W{1'b0}}} + NUMB_W'(nxl_q);
        numy_d  = {nyh_q, {MLO_W{1'b0}}} + NUMB_W'(nyl_q);
        state_d = P_CMP;
      end
      P_CMP: begin
        // The quotient overflows the cap when num << 8 >= den << 56.
        capx_d    = (den_q[DEN_W-1:DLOW_W] == '0) && (numx_q >= cap_lim);
        capy_d    = (den_q[DEN_W-1:DLOW_W] == '0) && (numy_q >= cap_lim);
        div_start = 1'b1;
        state_d   = P_DIV;
      end
      P_DIV: begin
        if (divx_done) begin
          tx_d    = nx_q ? -$signed(magx) : $signed(magx);
          ty_d    = ny_q ? -$signed(magy) : $signed(magy);
          state_d = P_DONE;
        end
      end
      P_DONE: begin
        state_d = P_IDLE;
      end
      default: begin
        state_d = P_IDLE;
      end
    endcase
  end

  nbgs_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({numx_q, {(NUM_W-NUMB_W){1'b0}}}),
    .den_i   (den_q),
    .done_o  (divx_done),
    .quot_o  (quox)
  );

  nbgs_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({numy_q, {(NUM_W-NUMB_W){1'b0}}}),
    .den_i   (den_q),
    .done_o  (divy_done),
    .quot_o  (quoy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= mx_d;   my_q <= my_d;   nx_q <= nx_d;   ny_q <= ny_d;
    mu_q <= mu_d;   soft_q <= soft_d;
    sqx_q <= sqx_d; sqy_q <= sqy_d;
    r2_q <= r2_d;   srem_q <= srem_d; sres_q <= sres_d; sbit_q <= sbit_d;
    plo_q <= plo_d; phi_q <= phi_d; den_q <= den_d;
    nxl_q <= nxl_d; nyl_q <= nyl_d; nxh_q <= nxh_d; nyh_q <= nyh_d;
    numx_q <= numx_d; numy_q <= numy_d;
    capx_q <= capx_d; capy_q <= capy_d;
    tx_q <= tx_d;   ty_q <= ty_d;
  end

  assign done_o   = (state_q == P_DONE);
  assign term_x_o = tx_q;
  assign term_y_o = ty_q;

  // Both dividers are started together and must finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) divx_done == divy_done)
    else $error("pair: divider lanes out of step");

endmodule

/* design/nbgs_upd.sv */
module nbgs_upd import nbgs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  body_t                   body_i,
  input  logic [DT_W-1:0]         dt_i,
  output logic                    done_o,
  output logic signed [POS_W-1:0] pos_x_o,
  output logic signed [POS_W-1:0] pos_y_o,
  output logic signed [POS_W-1:0] vel_x_o,
  output logic signed [POS_W-1:0] vel_y_o
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_ABS  = 3'd1;
  localparam logic [2:0] U_MLO  = 3'd2;
  localparam logic [2:0] U_MHI  = 3'd3;
  localparam logic [2:0] U_SCL  = 3'd4;
  localparam logic [2:0] U_ADD  = 3'd5;
  localparam logic [2:0] U_DONE = 3'd6;

  // Operand order: both velocities first, then both positions with the new velocity.
  localparam logic [1:0] OP_VX = 2'd0;
  localparam logic [1:0] OP_VY = 2'd1;
  localparam logic [1:0] OP_PX = 2'd2;
  localparam logic [1:0] OP_PY = 2'd3;

  localparam int HALF_W = ACC_W / 2;
  localparam int PR_W   = ACC_W + DT_W;
  localparam int SF_W   = PR_W - 12;
  localparam int CAPB   = 48;
  localparam int SUM_W  = DTT_W + 1;

  logic [2:0]               state_q, state_d;
  logic [1:0]               k_q, k_d;
  logic [DT_W-1:0]          dt_q, dt_d;
  logic signed [ACC_W-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic signed [POS_W-1:0]  px_q, px_d, py_q, py_d, vx_q, vx_d, vy_q, vy_d;
  logic                     neg_q, neg_d;
  logic [ACC_W-1:0]         mag_q, mag_d;
  logic [HALF_W+DT_W-1:0]   plo_q, plo_d, phi_q, phi_d;
  logic signed [DTT_W-1:0]  term_q, term_d;

  logic signed [ACC_W-1:0]  op;
  logic signed [POS_W-1:0]  base, sat;
  logic [PR_W-1:0]          prod;
  logic [SF_W-1:0]          sfull;
  logic [CAPB:0]            smag;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    case (k_q)
      OP_VX:   begin op = ax_q; base = vx_q; end
      OP_VY:   begin op = ay_q; base = vy_q; end
      OP_PX:   begin op = {{(ACC_W-POS_W){vx_q[POS_W-1]}}, vx_q}; base = px_q; end
      OP_PY:   begin op = {{(ACC_W-POS_W){vy_q[POS_W-1]}}, vy_q}; base = py_q; end
      default: begin op = ax_q; base = vx_q; end
    endcase
    prod  = {phi_q, {HALF_W{1'b0}}} + PR_W'(plo_q);
    sfull = prod[PR_W-1:12];
    smag  = (sfull > (SF_W'(1) << CAPB)) ? ((CAPB+1)'(1) << CAPB) : sfull[CAPB:0];
    sum   = {{(SUM_W-POS_W){base[POS_W-1]}}, base} + {term_q[DTT_W-1], term_q};
    if (sum[SUM_W-1:POS_W-1] == '0 || sum[SUM_W-1:POS_W-1] == '1) begin
      sat = sum[POS_W-1:0];
    end else begin
      sat = sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end

    state_d = state_q;
    k_d = k_q;   dt_d = dt_q;
    ax_d = ax_q; ay_d = ay_q;
    px_d = px_q; py_d = py_q; vx_d = vx_q; vy_d = vy_q;
    neg_d = neg_q; mag_d = mag_q; plo_d = plo_q; phi_d = phi_q; term_d = term_q;

    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          ax_d = body_i.acc_x; ay_d = body_i.acc_y;
          px_d = body_i.pos_x; py_d = body_i.pos_y;
          vx_d = body_i.vel_x; vy_d = body_i.vel_y;
          dt_d = dt_i;
          k_d  = OP_VX;
          state_d = U_ABS;
        end
      end
      U_ABS: begin
        neg_d   = op[ACC_W-1];
        mag_d   = op[ACC_W-1] ? ACC_W'(-op) : ACC_W'(op);
        state_d = U_MLO;
      end
      U_MLO: begin
        plo_d   = mag_q[HALF_W-1:0] * dt_q;
        state_d = U_MHI;
      end
      U_MHI: begin
        phi_d   = mag_q[ACC_W-1:HALF_W] * dt_q;
        state_d = U_SCL;
      end
      U_SCL: begin
        term_d  = neg_q ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
        state_d = U_ADD;
      end
      U_ADD: begin
        case (k_q)
          OP_VX:   vx_d = sat;
          OP_VY:   vy_d = sat;
          OP_PX:   px_d = sat;
          OP_PY:   py_d = sat;
          default: vx_d = sat;
        endcase
        if (k_q == OP_PY) begin
          state_d = U_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = U_ABS;
        end
      end
      U_DONE: begin
        state_d = U_IDLE;
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      k_q     <= OP_VX;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q <= dt_d;
    ax_q <= ax_d; ay_q <= ay_d;
    px_q <= px_d; py_q <= py_d; vx_q <= vx_d; vy_q <= vy_d;
    neg_q <= neg_d; mag_q <= mag_d; plo_q <= plo_d; phi_q <= phi_d; term_q <= term_d;
  end

  assign done_o  = (state_q == U_DONE);
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign vel_x_o = vx_q;
  assign vel_y_o = vy_q;

endmodule

/* design/nbody_gravity_step.sv */
// Two-dimensional softened direct-sum gravity with a semi-implicit Euler step.
// Input channel (in_if): a load transaction writes one body slot (position,
// velocity, gravitational parameter) and gives no result; slots at or above
// MaxBodies are ignored. A step transaction advances every body in use and
// gives one output transaction per body, in slot order, with last_body set on
// the final one. Input is taken only while no step is in progress.
// The bodies sit in a ring of cells that rotates at most one slot per cycle
// and holds while a pair, an update or an output is pending; the slot at the
// head of the ring feeds a shared pair unit (squares, a bit-serial square
// root, split multipliers and two bit-serial dividers).
// Results leave through an output register. When the receiver stalls the
// step waits in front of that register and loses nothing. Configuration is
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write it only
// while idle, which the block itself does not enforce.
// Reset clears the control state and the registers (body count 2, softening
// 1); body slots hold nothing defined until loaded.
module nbody_gravity_step import nbgs_pkg::*; #(
  parameter int MaxBodies = MaxBodiesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  nbgs_in_if.sink               in_if,
  nbgs_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = $clog2(MaxBodies);
  localparam int NW0   = $clog2(MaxBodies + 1);
  localparam int NCW   = (NW0 > CNT_W) ? NW0 : CNT_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LATCH = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PAIR  = 4'd3;
  localparam logic [3:0] S_STORE = 4'd4;
  localparam logic [3:0] S_HOME  = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_UWAIT = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [IDX_W-1:0]        head_q, head_d, i_q, i_d;
  logic [NCW-1:0]          n_q, n_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [SOFT_W-1:0]       soft_q, soft_d;
  logic [DT_W-1:0]         dt_q, dt_d;
  logic signed [POS_W-1:0] pix_q, pix_d, piy_q, piy_d;
  logic signed [ACC_W-1:0] sumx_q, sumx_d, sumy_q, sumy_d;

  logic                    ovalid_q, ovalid_d;
  logic [IDX_PORT_W-1:0]   oidx_q, oidx_d;
  logic signed [POS_W-1:0] opx_q, opx_d, opy_q, opy_d, ovx_q, ovx_d, ovy_q, ovy_d;
  logic                    olast_q, olast_d;

  body_t                   cell_out [MaxBodies];
  body_t                   ld_body, head_wdata, tail_in;
  logic                    in_fire, ld_en, shift, head_wr;
  logic [IDX_W-1:0]        ld_idx, head_nxt;
  logic [NCW-1:0]          head_ext, i_ext, cnt_ext, n_eff;
  logic                    pair_start, pair_done, upd_start, upd_done, emit_fire;
  logic signed [TERM_W-1:0] term_x, term_y;
  logic signed [POS_W-1:0] upx, upy, uvx, uvy;

  assign in_if.ready = (state_q == S_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign ld_en       = in_fire && (in_if.req_type == REQ_LOAD) &&
                       ({{(32-IDX_PORT_W){1'b0}}, in_if.body_index} < 32'(MaxBodies));
  assign ld_idx      = IDX_W'(in_if.body_index);

  always_comb begin
    ld_body       = '0;
    ld_body.pos_x = in_if.pos_x;
    ld_body.pos_y = in_if.pos_y;
    ld_body.vel_x = in_if.vel_x;
    ld_body.vel_y = in_if.vel_y;
    ld_body.mu    = in_if.grav_param;
  end

  // Ring of body cells; cell 0 is the head. A shift moves every body one
  // place toward the head, and the head body wraps to the tail, possibly
  // rewritten with its acceleration or its updated state.
  assign tail_in = head_wr ? head_wdata : cell_out[0];

  for (genvar c = 0; c < MaxBodies; c++) begin : g_cell
    body_t nxt;
    if (c == MaxBodies - 1) begin : g_tail
      assign nxt = tail_in;
    end else begin : g_mid
      assign nxt = cell_out[c+1];
    end
    nbgs_cell u_cell (
      .clk_i     (clk_i),
      .ld_i      (ld_en && (ld_idx == IDX_W'(c))),
      .ld_data_i (ld_body),
      .sh_i      (shift),
      .nxt_i     (nxt),
      .body_o    (cell_out[c])
    );
  end

  nbgs_pair u_pair (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (pair_start),
    .pi_x_i   (pix_q),
    .pi_y_i   (piy_q),
    .pj_x_i   (cell_out[0].pos_x),
    .pj_y_i   (cell_out[0].pos_y),
    .mu_i     (cell_out[0].mu),
    .soft_i   (soft_q),
    .done_o   (pair_done),
    .term_x_o (term_x),
    .term_y_o (term_y)
  );

  nbgs_upd u_upd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (upd_start),
    .body_i  (cell_out[0]),
    .dt_i    (dt_q),
    .done_o  (upd_done),
    .pos_x_o (upx),
    .pos_y_o (upy),
    .vel_x_o (uvx),
    .vel_y_o (uvy)
  );

  assign head_ext  = NCW'(head_q);
  assign i_ext     = NCW'(i_q);
  assign cnt_ext   = NCW'(count_q);
  assign n_eff     = (cnt_ext > NCW'(MaxBodies)) ? NCW'(MaxBodies) : cnt_ext;
  assign head_nxt  = (head_q == IDX_W'(MaxBodies - 1)) ? '0 : head_q + 1'b1;
  assign emit_fire = (state_q == S_EMIT) && (!ovalid_q || out_if.ready);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    i_d        = i_q;
    n_d        = n_q;
    dt_d       = dt_q;
    pix_d      = pix_q;
    piy_d      = piy_q;
    sumx_d     = sumx_q;
    sumy_d     = sumy_q;
    shift      = 1'b0;
    head_wr    = 1'b0;
    head_wdata = cell_out[0];
    pair_start = 1'b0;
    upd_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_if.req_type == REQ_STEP)) begin
          n_d  = n_eff;
          dt_d = in_if.step_time;
          i_d  = '0;
          if (n_eff != '0) begin
            state_d = S_LATCH;
          end
        end
      end
      // Body i is at the head: keep its position and skip the self pair.
      S_LATCH: begin
        pix_d   = cell_out[0].pos_x;
        piy_d   = cell_out[0].pos_y;
        sumx_d  = '0;
        sumy_d  = '0;
        shift   = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (head_q == i_q) begin
          state_d = S_STORE;
        end else if (head_ext < n_q) begin
          pair_start = 1'b1;
          state_d    = S_PAIR;
        end else begin
          shift = 1'b1;
        end
      end
      S_PAIR: begin
        if (pair_done) begin
          sumx_d  = sumx_q + {{(ACC_W-TERM_W){term_x[TERM_W-1]}}, term_x};
          sumy_d  = sumy_q + {{(ACC_W-TERM_W){term_y[TERM_W-1]}}, term_y};
          shift   = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_STORE: begin
        head_wr          = 1'b1;
        head_wdata.acc_x = sumx_q;
        head_wdata.acc_y = sumy_q;
        shift            = 1'b1;
        if (i_ext == n_q - 1'b1) begin
          state_d = S_HOME;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_LATCH;
        end
      end
      // Turn the ring back to slot 0 before the update pass.
      S_HOME: begin
        if (head_q == '0) begin
          state_d = S_UPD;
        end else begin
          shift = 1'b1;
        end
      end
      S_UPD: begin
        if (head_ext < n_q) begin
          upd_start = 1'b1;
          state_d   = S_UWAIT;
        end else begin
          shift = 1'b1;
          if (head_q == IDX_W'(MaxBodies - 1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_UWAIT: begin
        if (upd_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          head_wr          = 1'b1;
          head_wdata.pos_x = upx;
          head_wdata.pos_y = upy;
          head_wdata.vel_x = uvx;
          head_wdata.vel_y = uvy;
          shift            = 1'b1;
          if (head_q == IDX_W'(MaxBodies - 1)) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_UPD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (shift) begin
      head_d = head_nxt;
    end
  end

  // Output register.
  always_comb begin
    ovalid_d = ovalid_q;
    oidx_d   = oidx_q;
    opx_d    = opx_q;
    opy_d    = opy_q;
    ovx_d    = ovx_q;
    ovy_d    = ovy_q;
    olast_d  = olast_q;
    if (emit_fire) begin
      ovalid_d = 1'b1;
      oidx_d   = IDX_PORT_W'(head_q);
      opx_d    = upx;
      opy_d    = upy;
      ovx_d    = uvx;
      ovy_d    = uvy;
      olast_d  = (head_ext == n_q - 1'b1);
    end else if (out_if.ready) begin
      ovalid_d = 1'b0;
    end
  end

  // Configuration registers.
  always_comb begin
    count_d = count_q;
    soft_d  = soft_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BODY_COUNT:   count_d = cfg_wdata_i[CNT_W-1:0];
        REG_SOFTENING_SQ: soft_d  = cfg_wdata_i[SOFT_W-1:0];
        default:          count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      i_q      <= '0;
      n_q      <= '0;
      ovalid_q <= 1'b0;
      count_q  <= BODY_COUNT_RST;
      soft_q   <= SOFT_RST;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      i_q      <= i_d;
      n_q      <= n_d;
      ovalid_q <= ovalid_d;
      count_q  <= count_d;
      soft_q   <= soft_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    pix_q  <= pix_d;
    piy_q  <= piy_d;
    sumx_q <= sumx_d;
    sumy_q <= sumy_d;
    oidx_q <= oidx_d;
    opx_q  <= opx_d;
    opy_q  <= opy_d;
    ovx_q  <= ovx_d;
    ovy_q  <= ovy_d;
    olast_q <= olast_d;
  end

  assign out_if.valid     = ovalid_q;
  assign out_if.out_index = oidx_q;
  assign out_if.out_pos_x = opx_q;
  assign out_if.out_pos_y = opy_q;
  assign out_if.out_vel_x = ovx_q;
  assign out_if.out_vel_y = ovy_q;
  assign out_if.last_body = olast_q;

  // The ring is back at slot 0 whenever the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> head_q == '0)
    else $error("ring not aligned while idle");

  // A pair is never formed with the body itself or with an unused slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_start |-> (head_q != i_q) && (head_ext < n_q))
    else $error("invalid pair started");

  // An update is only started for a slot in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_start |-> head_ext < n_q)
    else $error("update started on unused slot");

  // A result handed to the output register is presented next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> out_if.valid && (out_if.out_index == $past(IDX_PORT_W'(head_q))))
    else $error("emitted result not presented");

endmodule

/* tb/nbody_gravity_step_tb.sv */
`timescale 1ns / 100ps

// Testbench for nbody_gravity_step.
// A directed table runs first, then random phases. Each phase writes the
// configuration while the block is idle and then sends a mix of loads and
// steps. A predictor in this file keeps its own copy of the body slots and
// the registers. For every accepted step it queues the expected bodies. A
// monitor compares each output transaction with the oldest expected body.
module nbody_gravity_step_tb;
  import nbgs_pkg::*;

  localparam int NSLOT       = MaxBodiesDef;
  localparam int WATCH_LIMIT = 150000;
  localparam int SETTLE      = 40;      // wait after the last result until the block is idle again

  typedef enum logic { ROW_SEND, ROW_CFG } row_kind_e;

  typedef struct {
    logic                    req;
    logic [IDX_PORT_W-1:0]   idx;
    logic signed [POS_W-1:0] px, py, vx, vy;
    logic [MU_W-1:0]         mu;
    logic [DT_W-1:0]         dt;
  } request_t;

  typedef struct {
    logic [IDX_PORT_W-1:0]   idx;
    logic signed [POS_W-1:0] px, py, vx, vy;
    logic                    last;
  } body_out_t;

  typedef struct {
    row_kind_e              kind;
    request_t               item;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    logic                   pinned;   // expected result typed in below
    body_out_t              pin_res;
  } table_row_t;

  logic clk_i;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nbgs_in_if  in_bus ();
  nbgs_out_if out_bus ();

  nbody_gravity_step u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_bus),
    .out_if     (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Predictor state: the body slots and the two registers.
  longint      slot_px [NSLOT];
  longint      slot_py [NSLOT];
  longint      slot_vx [NSLOT];
  longint      slot_vy [NSLOT];
  logic [31:0] slot_mu [NSLOT];
  logic [4:0]  bodies_in_use;
  logic [31:0] soft_sq;

  body_out_t expected_bodies[$];
  table_row_t stim_table[$];
  int  errors;
  logic idle_on;      // random idling on both sides
  logic long_hold;    // receiver holds off for a long stretch
  logic pin_next;     // next step uses the typed result, not the predictor
  body_out_t pin_val;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic of the predictor.
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= res + probe) begin
        v = v - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res = res >> 1;
      end
      probe = probe >> 2;
    end
    return res;
  endfunction

  // One force component: (mu*|d| << 8) / den, floored and capped at 2^56.
  function automatic longint force_part(logic [31:0] mu, logic [63:0] mag,
                                        logic [127:0] den);
    logic [127:0] num, quo;
    num = (128'(mu) * 128'(mag)) << 8;
    quo = num / den;
    if (quo >= (128'd1 << 56)) return longint'(64'd1 << 56);
    return longint'(quo[63:0]);
  endfunction

  // Value times dt (Q20.12), truncated toward zero, magnitude capped at 2^48.
  function automatic longint scale_by_dt(longint x, logic [31:0] dt);
    logic [63:0]  m;
    logic [127:0] p;
    m = (x < 0) ? 64'(-x) : 64'(x);
    p = (128'(m) * 128'(dt)) >> 12;
    if (p > (128'd1 << 48)) p = 128'd1 << 48;
    return (x < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp48(longint v);
    if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
    if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
    return v;
  endfunction

  function automatic logic [63:0] trunc_sq(logic [63:0] m);
    logic [63:0] t;
    t = m >> 16;
    return (t * t) >> 16;
  endfunction

  // Applies one accepted request to the predictor state and queues results.
  task automatic apply_request(request_t it);
    longint      acc_x [NSLOT];
    longint      acc_y [NSLOT];
    int          n;
    longint      dx, dy, sx, sy, t;
    logic [63:0] mx, my, r2, rt;
    body_out_t   res;
    if (it.req == REQ_LOAD) begin
      slot_px[it.idx] = it.px;
      slot_py[it.idx] = it.py;
      slot_vx[it.idx] = it.vx;
      slot_vy[it.idx] = it.vy;
      slot_mu[it.idx] = it.mu;
      return;
    end
    n = (bodies_in_use > NSLOT) ? NSLOT : int'(bodies_in_use);
    // All accelerations come from the old positions.
    for (int i = 0; i < n; i++) begin
      sx = 0;
      sy = 0;
      for (int j = 0; j < n; j++) begin
        if (j == i) continue;
        dx = slot_px[j] - slot_px[i];
        dy = slot_py[j] - slot_py[i];
        mx = (dx < 0) ? 64'(-dx) : 64'(dx);
        my = (dy < 0) ? 64'(-dy) : 64'(dy);
        r2 = trunc_sq(mx) + trunc_sq(my) + 64'(soft_sq);
        if (r2 == 0) continue;  // coincident bodies with no softening
        rt = floor_sqrt(r2);
        t = force_part(slot_mu[j], mx, 128'(r2) * 128'(rt));
        sx = (dx < 0) ? sx - t : sx + t;
        t = force_part(slot_mu[j], my, 128'(r2) * 128'(rt));
        sy = (dy < 0) ? sy - t : sy + t;
      end
      acc_x[i] = sx;
      acc_y[i] = sy;
    end
    // Semi-implicit Euler: the position moves with the new velocity.
    for (int i = 0; i < n; i++) begin
      slot_vx[i] = clamp48(slot_vx[i] + scale_by_dt(acc_x[i], it.dt));
      slot_vy[i] = clamp48(slot_vy[i] + scale_by_dt(acc_y[i], it.dt));
      slot_px[i] = clamp48(slot_px[i] + scale_by_dt(slot_vx[i], it.dt));
      slot_py[i] = clamp48(slot_py[i] + scale_by_dt(slot_vy[i], it.dt));
      res.idx  = 4'(i);
      res.px   = 48'(slot_px[i]);
      res.py   = 48'(slot_py[i]);
      res.vx   = 48'(slot_vx[i]);
      res.vy   = 48'(slot_vy[i]);
      res.last = (i + 1 == n);
      expected_bodies.push_back(pin_next ? pin_val : res);
    end
    pin_next = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------

  // Offers one transaction and waits for it to be taken. The valid line stays
  // high when no gap follows, so the next call only changes the payload.
  task automatic send_request(request_t it);
    @(negedge clk_i);
    in_bus.valid      <= 1'b1;
    in_bus.req_type   <= it.req;
    in_bus.body_index <= it.idx;
    in_bus.pos_x      <= it.px;
    in_bus.pos_y      <= it.py;
    in_bus.vel_x      <= it.vx;
    in_bus.vel_y      <= it.vy;
    in_bus.grav_param <= it.mu;
    in_bus.step_time  <= it.dt;
    do @(posedge clk_i); while (!in_bus.ready);
    apply_request(it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  // Waits until every expected body has arrived and the block has settled,
  // then writes one register.
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_bodies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_BODY_COUNT) bodies_in_use = val[4:0];
    else soft_sq = val;
  endtask

  function automatic request_t load_of(int slot, longint px, longint py, longint vx,
                                       longint vy, logic [31:0] mu);
    request_t it;
    it.req = REQ_LOAD;
    it.idx = 4'(slot);
    it.px = 48'(px);
    it.py = 48'(py);
    it.vx = 48'(vx);
    it.vy = 48'(vy);
    it.mu = mu;
    it.dt = 32'($urandom);  // ignored by a load
    return it;
  endfunction

  function automatic request_t step_of(logic [31:0] dt);
    request_t it;
    it.req = REQ_STEP;
    it.idx = 4'($urandom);  // the payload of a step is ignored
    it.px = {16'($urandom), 32'($urandom)};
    it.py = {16'($urandom), 32'($urandom)};
    it.vx = {16'($urandom), 32'($urandom)};
    it.vy = {16'($urandom), 32'($urandom)};
    it.mu = 32'($urandom);
    it.dt = dt;
    return it;
  endfunction

  // Well-formed random body: integer position parts within 1000 of zero, modest speed and mass.
  function automatic request_t sane_load(int slot);
    int ip, iq, iv, iw;
    ip = $urandom_range(0, 2000) - 1000;
    iq = $urandom_range(0, 2000) - 1000;
    iv = $urandom_range(0, 100) - 50;
    iw = $urandom_range(0, 100) - 50;
    return load_of(slot, {ip[15:0], 32'($urandom)}, {iq[15:0], 32'($urandom)},
                   {iv[15:0], 32'($urandom)}, {iw[15:0], 32'($urandom)},
                   32'($urandom_range(0, 32'h0100_0000)));
  endfunction

  function automatic request_t noise_request();
    request_t it;
    it = step_of(32'($urandom));
    it.req = 1'($urandom);
    return it;
  endfunction

  function automatic void add_send(request_t it);
    table_row_t r;
    r.kind = ROW_SEND;
    r.item = it;
    r.pinned = 1'b0;
    stim_table.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    table_row_t r;
    r.kind = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = val;
    r.pinned = 1'b0;
    stim_table.push_back(r);
  endfunction

  // Directed table: a lone body at dt zero, the extremes of every field,
  // saturation, coincident bodies without softening, and a body count of zero.
  task automatic build_table();
    table_row_t r;
    longint p_max, p_min;
    p_max = 64'sh7FFF_FFFF_FFFF;
    p_min = -64'sh8000_0000_0000;
    add_send(load_of(0, 64'sd5 << 32, -(64'sd3 << 32), 64'sd1 << 31, -(64'sd1 << 30),
                     32'h0001_0000));
    add_cfg(REG_BODY_COUNT, 32'd1);
    // A single body with dt zero comes back exactly as it was loaded.
    r.kind = ROW_SEND;
    r.item = step_of(32'd0);
    r.pinned = 1'b1;
    r.pin_res = '{idx: 4'd0, px: 48'sh0005_0000_0000, py: -48'sh0003_0000_0000,
                  vx: 48'sh0000_8000_0000, vy: -48'sh0000_4000_0000, last: 1'b1};
    stim_table.push_back(r);
    add_send(step_of(32'hFFFF_FFFF));  // lone body drifts with no force
    add_send(load_of(1, 64'sd20 << 32, 64'sd7 << 32, 0, 0, 32'h0040_0000));
    add_cfg(REG_BODY_COUNT, 32'd2);
    add_send(step_of(32'd4096));
    add_send(load_of(0, p_max, p_min, p_max, p_min, 32'hFFFF_FFFF));
    add_send(load_of(1, p_min, p_max, p_min, p_max, 32'hFFFF_FFFF));
    add_send(step_of(32'hFFFF_FFFF));  // everything saturates
    add_send(load_of(0, p_min, p_max, 0, 0, 32'd0));
    add_send(load_of(1, p_max, p_min, 0, 0, 32'hFFFF_FFFF));
    add_send(step_of(32'd1));
    add_cfg(REG_SOFTENING_SQ, 32'd0);
    add_send(load_of(0, 64'sd9 << 32, 64'sd9 << 32, 64'sd1 << 32, 0, 32'h0010_0000));
    add_send(load_of(1, 64'sd9 << 32, 64'sd9 << 32, 0, 64'sd1 << 32, 32'h0010_0000));
    add_send(step_of(32'd4096));  // coincident pair contributes nothing
    add_cfg(REG_SOFTENING_SQ, 32'hFFFF_FFFF);
    add_send(step_of(32'd8192));
    add_cfg(REG_BODY_COUNT, 32'd0);
    add_send(step_of(32'd4096));  // no bodies in use, no output
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and checker.
  // ---------------------------------------------------------------------------

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        // Hold off long enough that the output register fills and the
        // block stops taking input.
        out_bus.ready <= 1'b0;
        repeat (2500) @(negedge clk_i);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    body_out_t e;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected_bodies.size() == 0) begin
        $display("%0t mismatch: expected no transaction, actual body %0d",
                 $time, out_bus.out_index);
        errors++;
      end else begin
        e = expected_bodies.pop_front();
        check_field("out_index", 48'(e.idx), 48'(out_bus.out_index));
        check_field("out_pos_x", e.px, out_bus.out_pos_x);
        check_field("out_pos_y", e.py, out_bus.out_pos_y);
        check_field("out_vel_x", e.vx, out_bus.out_vel_x);
        check_field("out_vel_y", e.vy, out_bus.out_vel_y);
        check_field("last_body", 48'(e.last), 48'(out_bus.last_body));
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on either side.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCH_LIMIT) begin
      $display("FAIL nbody_gravity_step");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    int        n_items;
    logic [4:0] cnt;
    logic [31:0] soft_val;
    request_t  it;
    errors = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    pin_next = 1'b0;
    bodies_in_use = BODY_COUNT_RST;
    soft_sq = SOFT_RST;
    for (int s = 0; s < NSLOT; s++) begin
      slot_px[s] = 0;
      slot_py[s] = 0;
      slot_vx[s] = 0;
      slot_vy[s] = 0;
      slot_mu[s] = 0;
    end
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_LOAD;
    in_bus.body_index = '0;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.vel_x = '0;
    in_bus.vel_y = '0;
    in_bus.grav_param = '0;
    in_bus.step_time = '0;
    cfg_we = 1'b0;
    cfg_idx = REG_BODY_COUNT;
    cfg_wdata = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    build_table();
    foreach (stim_table[k]) begin
      if (stim_table[k].kind == ROW_CFG) begin
        write_register(stim_table[k].reg_idx, stim_table[k].reg_val);
      end else begin
        pin_next = stim_table[k].pinned;
        pin_val = stim_table[k].pin_res;
        send_request(stim_table[k].item);
      end
    end

    // Fill every slot so that any body count reads only loaded slots.
    for (int s = 0; s < NSLOT; s++) send_request(sane_load(s));

    for (int ph = 0; ph < 18; ph++) begin
      idle_on = (ph < 15);  // the closing phases run without idling
      case (ph)
        2:       cnt = 5'd3;
        4:       cnt = 5'd16;
        9:       cnt = 5'd31;  // above the slot count, acts as all slots
        11:      cnt = 5'd1;
        13:      cnt = 5'd0;
        default: cnt = 5'($urandom_range(2, 5));
      endcase
      case (ph)
        3:       soft_val = 32'd0;
        7:       soft_val = 32'hFFFF_FFFF;
        default: soft_val = 32'($urandom_range(1, 32'h0040_0000));
      endcase
      write_register(REG_BODY_COUNT, 32'(cnt));
      write_register(REG_SOFTENING_SQ, soft_val);
      n_items = (cnt >= 16) ? 4 : 8;
      for (int k = 0; k < n_items; k++) begin
        if (cnt >= 16 && k != n_items - 1) begin
          it = sane_load($urandom_range(0, NSLOT - 1));
        end else if ($urandom_range(0, 7) == 0) begin
          it = noise_request();
          if (cnt >= 16) it.req = REQ_LOAD;
        end else if ($urandom_range(0, 1) == 0) begin
          it = sane_load($urandom_range(0, NSLOT - 1));
        end else begin
          it = step_of(32'($urandom_range(1, 8192)));
        end
        send_request(it);
        // In phase 2 the receiver stalls right after every step while loads keep coming.
        if (ph == 2 && it.req == REQ_STEP && !long_hold) long_hold = 1'b1;
      end
      if (ph == 2 && !long_hold) begin
        long_hold = 1'b1;
        send_request(step_of(32'd4096));
        send_request(sane_load(0));
      end
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_bodies.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS nbody_gravity_step");
    end else begin
      $display("FAIL nbody_gravity_step");
    end
    $finish;
  end

endmodule
